@@ rtl/hpk_pkg.sv @@
// Shared types, codes and helpers for the HPACK header block tokenizer.
// No dependencies; used by hpk_parser and the top level.
package hpk_pkg;

  localparam int INT_BITS          = 28;
  localparam int STATIC_TABLE_LAST = 61;
  localparam int IDX_W             = 28;   // width of the field_index port field
  localparam int SUM_W             = ((INT_BITS > 28) ? INT_BITS : 28) + 1;
  localparam int OUT_DATA_W        = 48;   // 43 field bits padded to whole bytes

  // byte roles
  localparam logic [2:0] ROLE_PREFIX = 3'd0;
  localparam logic [2:0] ROLE_CONT   = 3'd1;
  localparam logic [2:0] ROLE_STRLEN = 3'd2;
  localparam logic [2:0] ROLE_NAME   = 3'd3;
  localparam logic [2:0] ROLE_VALUE  = 3'd4;
  localparam logic [2:0] ROLE_SKIP   = 3'd5;

  // representation kinds
  localparam logic [2:0] KIND_INDEXED = 3'd0;
  localparam logic [2:0] KIND_INCR    = 3'd1;
  localparam logic [2:0] KIND_NOIDX   = 3'd2;
  localparam logic [2:0] KIND_NEVER   = 3'd3;
  localparam logic [2:0] KIND_SIZE    = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ZERO_IDX  = 2'd1;
  localparam logic [1:0] ERR_TRUNC     = 2'd2;
  localparam logic [1:0] ERR_INT_LONG  = 2'd3;

  localparam logic [2:0] MAX_CONT = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_SKIP          = 4'd1,
    PH_REP           = 4'd2,
    PH_INT_CONT      = 4'd3,
    PH_NAME_LEN      = 4'd4,
    PH_NAME_LEN_CONT = 4'd5,
    PH_NAME_BYTES    = 4'd6,
    PH_VAL_LEN       = 4'd7,
    PH_VAL_LEN_CONT  = 4'd8,
    PH_VAL_BYTES     = 4'd9,
    PH_ERR           = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    CTX_REP  = 2'd0,
    CTX_NAME = 2'd1,
    CTX_VAL  = 2'd2
  } ctx_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       block_start;
    logic       block_end;
    logic       padded_flag;
    logic       priority_flag;
  } item_t;

  typedef struct packed {
    logic [2:0]       byte_role;
    logic [7:0]       data_byte;
    logic             string_huffman;
    logic             field_done;
    logic [2:0]       field_kind;
    logic [IDX_W-1:0] field_index;
    logic             dynamic_ref;
    logic [1:0]       error_code;
    logic             block_done;
  } result_t;

  // bit offset of the n-th continuation byte (n = 1..4)
  function automatic logic [4:0] cont_shift(input logic [2:0] n);
    logic [4:0] s;
    s = 5'd0;
    unique case (n)
      3'd2:    s = 5'd7;
      3'd3:    s = 5'd14;
      3'd4:    s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/hpk_parser.sv @@
// Per-byte parse step and parser state of the HPACK tokenizer.
// Depends on hpk_pkg. Result is combinational from the registered input byte.
module hpk_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  hpk_pkg::item_t   item,
  output hpk_pkg::result_t res
);

  localparam logic [hpk_pkg::INT_BITS-1:0] LIM = {hpk_pkg::INT_BITS{1'b1}};

  hpk_pkg::phase_t               phase_r, phase_nxt;
  logic [2:0]                    skip_r, skip_nxt;
  logic [2:0]                    kind_r, kind_nxt;
  logic [hpk_pkg::INT_BITS-1:0]  acc_r, acc_nxt;
  logic [2:0]                    cnt_r, cnt_nxt;
  logic [hpk_pkg::INT_BITS-1:0]  str_r, str_nxt;
  logic                          huff_r, huff_nxt;
  logic [hpk_pkg::INT_BITS-1:0]  idx_r, idx_nxt;
  logic [1:0]                    err_r, err_nxt;

  always_comb begin
    hpk_pkg::phase_t              ph;
    logic [2:0]                   skip, kind, cnt;
    logic [hpk_pkg::INT_BITS-1:0] acc, str, idx, finv;
    logic                         huff, fin, done, is_cont, huff_o;
    logic [1:0]                   err;
    hpk_pkg::ctx_t                fctx, cctx;
    logic [2:0]                   role;
    logic [6:0]                   prefix, maxp;
    logic [7:0]                   b;
    logic [hpk_pkg::SUM_W-1:0]    sum;

    b      = item.payload_byte;
    ph     = phase_r;
    skip   = skip_r;
    kind   = kind_r;
    acc    = acc_r;
    cnt    = cnt_r;
    str    = str_r;
    huff   = huff_r;
    idx    = idx_r;
    err    = err_r;
    fin    = 1'b0;
    finv   = '0;
    fctx   = hpk_pkg::CTX_REP;
    cctx   = hpk_pkg::CTX_REP;
    done   = 1'b0;
    is_cont = 1'b0;
    huff_o = 1'b0;
    role   = hpk_pkg::ROLE_SKIP;
    prefix = 7'd0;
    maxp   = 7'd0;
    sum    = '0;

    if (item.block_start) begin
      skip = {2'b00, item.padded_flag} + (item.priority_flag ? 3'd5 : 3'd0);
      kind = 3'd0;
      acc  = '0;
      cnt  = 3'd0;
      str  = '0;
      huff = 1'b0;
      idx  = '0;
      err  = hpk_pkg::ERR_NONE;
      ph   = (skip != 3'd0) ? hpk_pkg::PH_SKIP : hpk_pkg::PH_REP;
    end

    unique case (ph)
      hpk_pkg::PH_SKIP: begin
        if (skip != 3'd0) skip = skip - 3'd1;
        if (skip == 3'd0) ph = hpk_pkg::PH_REP;
      end
      hpk_pkg::PH_REP: begin
        role = hpk_pkg::ROLE_PREFIX;
        priority if (b[7]) begin
          kind = hpk_pkg::KIND_INDEXED; prefix = b[6:0];         maxp = 7'h7f;
        end else if (b[6]) begin
          kind = hpk_pkg::KIND_INCR;    prefix = {1'b0, b[5:0]}; maxp = 7'h3f;
        end else if (b[5]) begin
          kind = hpk_pkg::KIND_SIZE;    prefix = {2'b0, b[4:0]}; maxp = 7'h1f;
        end else if (b[4]) begin
          kind = hpk_pkg::KIND_NEVER;   prefix = {3'b0, b[3:0]}; maxp = 7'h0f;
        end else begin
          kind = hpk_pkg::KIND_NOIDX;   prefix = {3'b0, b[3:0]}; maxp = 7'h0f;
        end
        if (prefix != maxp) begin
          fin = 1'b1; finv = hpk_pkg::INT_BITS'(prefix); fctx = hpk_pkg::CTX_REP;
        end else begin
          acc = hpk_pkg::INT_BITS'(maxp); cnt = 3'd0; ph = hpk_pkg::PH_INT_CONT;
        end
      end
      hpk_pkg::PH_INT_CONT: begin
        role = hpk_pkg::ROLE_CONT; is_cont = 1'b1; cctx = hpk_pkg::CTX_REP;
      end
      hpk_pkg::PH_NAME_LEN, hpk_pkg::PH_VAL_LEN: begin
        role   = hpk_pkg::ROLE_STRLEN;
        huff   = b[7];
        huff_o = b[7];
        fctx   = (ph == hpk_pkg::PH_NAME_LEN) ? hpk_pkg::CTX_NAME : hpk_pkg::CTX_VAL;
        if (b[6:0] != 7'h7f) begin
          fin = 1'b1; finv = hpk_pkg::INT_BITS'(b[6:0]);
        end else begin
          acc = hpk_pkg::INT_BITS'(7'h7f); cnt = 3'd0;
          ph  = (ph == hpk_pkg::PH_NAME_LEN) ? hpk_pkg::PH_NAME_LEN_CONT
                                             : hpk_pkg::PH_VAL_LEN_CONT;
        end
      end
      hpk_pkg::PH_NAME_LEN_CONT: begin
        role = hpk_pkg::ROLE_CONT; huff_o = huff; is_cont = 1'b1; cctx = hpk_pkg::CTX_NAME;
      end
      hpk_pkg::PH_VAL_LEN_CONT: begin
        role = hpk_pkg::ROLE_CONT; huff_o = huff; is_cont = 1'b1; cctx = hpk_pkg::CTX_VAL;
      end
      hpk_pkg::PH_NAME_BYTES: begin
        role = hpk_pkg::ROLE_NAME; huff_o = huff;
        if (str != '0) str = str - hpk_pkg::INT_BITS'(1);
        if (str == '0) ph = hpk_pkg::PH_VAL_LEN;
      end
      hpk_pkg::PH_VAL_BYTES: begin
        role = hpk_pkg::ROLE_VALUE; huff_o = huff;
        if (str != '0) str = str - hpk_pkg::INT_BITS'(1);
        if (str == '0) begin
          done = 1'b1; ph = hpk_pkg::PH_REP;
        end
      end
      default: begin
      end
    endcase

    // continuation byte of any prefix integer, saturating
    if (is_cont) begin
      cnt = cnt + 3'd1;
      if (cnt > hpk_pkg::MAX_CONT) begin
        if (err == hpk_pkg::ERR_NONE) err = hpk_pkg::ERR_INT_LONG;
        ph = hpk_pkg::PH_ERR;
      end else begin
        sum = hpk_pkg::SUM_W'(acc)
            + (hpk_pkg::SUM_W'(b[6:0]) << hpk_pkg::cont_shift(cnt));
        acc = (sum > hpk_pkg::SUM_W'(LIM)) ? LIM : hpk_pkg::INT_BITS'(sum);
        if (!b[7]) begin
          fin = 1'b1; finv = acc; fctx = cctx;
        end
      end
    end

    if (fin) begin
      unique case (fctx)
        hpk_pkg::CTX_REP: begin
          idx = finv;
          if (kind == hpk_pkg::KIND_INDEXED) begin
            if (finv == '0) begin
              if (err == hpk_pkg::ERR_NONE) err = hpk_pkg::ERR_ZERO_IDX;
              ph = hpk_pkg::PH_ERR;
            end else begin
              done = 1'b1; ph = hpk_pkg::PH_REP;
            end
          end else if (kind == hpk_pkg::KIND_SIZE) begin
            done = 1'b1; ph = hpk_pkg::PH_REP;
          end else begin
            ph = (finv == '0) ? hpk_pkg::PH_NAME_LEN : hpk_pkg::PH_VAL_LEN;
          end
        end
        hpk_pkg::CTX_NAME: begin
          if (finv == '0) ph = hpk_pkg::PH_VAL_LEN;
          else begin
            str = finv; ph = hpk_pkg::PH_NAME_BYTES;
          end
        end
        default: begin
          if (finv == '0) begin
            done = 1'b1; ph = hpk_pkg::PH_REP;
          end else begin
            str = finv; ph = hpk_pkg::PH_VAL_BYTES;
          end
        end
      endcase
    end

    // block ends with a skip, integer or string still open
    if (item.block_end && err == hpk_pkg::ERR_NONE && ph != hpk_pkg::PH_IDLE &&
        ph != hpk_pkg::PH_REP && ph != hpk_pkg::PH_ERR)
      err = hpk_pkg::ERR_TRUNC;

    res.byte_role      = role;
    res.data_byte      = b;
    res.string_huffman = huff_o;
    res.field_done     = done;
    res.field_kind     = done ? kind : 3'd0;
    res.field_index    = done ? hpk_pkg::IDX_W'(idx) : '0;
    res.dynamic_ref    = done && (kind != hpk_pkg::KIND_SIZE) &&
                         (idx > hpk_pkg::INT_BITS'(hpk_pkg::STATIC_TABLE_LAST));
    res.error_code     = err;
    res.block_done     = item.block_end;

    if (item.block_end) begin
      phase_nxt = hpk_pkg::PH_IDLE;
      skip_nxt  = 3'd0;
      kind_nxt  = 3'd0;
      acc_nxt   = '0;
      cnt_nxt   = 3'd0;
      str_nxt   = '0;
      huff_nxt  = 1'b0;
      idx_nxt   = '0;
      err_nxt   = hpk_pkg::ERR_NONE;
    end else begin
      phase_nxt = ph;
      skip_nxt  = skip;
      kind_nxt  = kind;
      acc_nxt   = acc;
      cnt_nxt   = cnt;
      str_nxt   = str;
      huff_nxt  = huff;
      idx_nxt   = idx;
      err_nxt   = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hpk_pkg::PH_IDLE;
      skip_r  <= 3'd0;
      kind_r  <= 3'd0;
      acc_r   <= '0;
      cnt_r   <= 3'd0;
      str_r   <= '0;
      huff_r  <= 1'b0;
      idx_r   <= '0;
      err_r   <= hpk_pkg::ERR_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      kind_r  <= kind_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      str_r   <= str_nxt;
      huff_r  <= huff_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ rtl/hpack_header_block_tokenizer_unit.sv @@
// Top level of the HPACK header block tokenizer: input and result registers
// around the per-byte parser. Depends on hpk_pkg and hpk_parser.
//
//  channel | dir | tdata                         | tuser                   | tlast
//  in_     | in  | payload byte                  | start, padded, priority | block end
//  out_    | out | byte, done, kind, index, ...  | role, huffman           | block done
//
// One byte per cycle sustained while out_tready is high; each word passes the input and result registers.
// The parse step is one pass of shallow logic from the input register.
// Synchronous active-low reset clears the parser state and both valid flags.
// A stall on out_tready holds the result register and backs up into the
// input register; in_tready drops only when both are full.
module hpack_header_block_tokenizer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] payload_byte
  input  logic [2:0]                     in_tuser,   // [0] block_start, [1] padded_flag,
                                                     // [2] priority_flag
  input  logic                           in_tlast,   // block_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hpk_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] data_byte, [8] field_done,
                                                     // [11:9] field_kind,
                                                     // [39:12] field_index,
                                                     // [40] dynamic_ref,
                                                     // [42:41] error_code, rest zero
  output logic [3:0]                     out_tuser,  // [2:0] byte_role, [3] string_huffman
  output logic                           out_tlast   // block_done
);

  logic             in_valid_r;
  hpk_pkg::item_t   in_item_r;
  logic             out_valid_r;
  hpk_pkg::result_t out_res_r;
  hpk_pkg::result_t res;
  logic             adv;
  logic             step;

  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.payload_byte  <= in_tdata;
      in_item_r.block_start   <= in_tuser[0];
      in_item_r.block_end     <= in_tlast;
      in_item_r.padded_flag   <= in_tuser[1];
      in_item_r.priority_flag <= in_tuser[2];
    end
    if (step) out_res_r <= res;
  end

  hpk_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.error_code, out_res_r.dynamic_ref,
                       out_res_r.field_index, out_res_r.field_kind,
                       out_res_r.field_done, out_res_r.data_byte};
  assign out_tuser  = {out_res_r.string_huffman, out_res_r.byte_role};
  assign out_tlast  = out_res_r.block_done;

endmodule
